// ===== hdl/deq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg - shared types for the double-ended queue ring core
// Command and status codes carried on the stream channels.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Command codes in the low bits of in_tdata
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_LIST       = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_t;

  // Status codes on out_tuser
  typedef enum logic [2:0] {
    ST_PUSHED  = 3'd0,
    ST_POPPED  = 3'd1,
    ST_LISTED  = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned IN_W    = 40;
  localparam int unsigned OUT_W   = 32;

endpackage
`default_nettype wire

// ===== hdl/deq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ram - generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered and holds
// while rd_en is low.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/double_ended_queue_ring_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_ring_core - double-ended queue over a ring RAM
// Commands arrive on the in_ stream; one or more result beats leave on out_.
// ----------------------------------------------------------------------------
// Usage:
//   in_tdata carries a command (push front/back, pop front/back, list, clear)
//   and a 32-bit signed value. Each command returns one result beat with
//   tlast set, except list, which returns one beat per stored entry from
//   front to back with tlast on the final one. Unknown commands are dropped.
//   Timing: push, clear, full and empty results appear in the cycle after the
//   input beat, and a new command is taken every cycle while the block is idle
//   and the output slot is free. A pop passes through the registered read of
//   the entry RAM and the output register; a list busies the block, one RAM read per entry.
//   Reset clears the front pointer and the fill count; the RAM itself is not
//   swept, since only written entries are ever read. Clear works the same way.
//   A stalled receiver holds the result beat in the output register; the
//   block then stops taking input and pauses a list until the beat drains.
// ----------------------------------------------------------------------------
module double_ended_queue_ring_core #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [39:0]       in_tdata,   // [2:0] command, [34:3] value, [39:35] zero
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [31:0]            out_tdata,  // [31:0] data
  output deq_pkg::status_t       out_tuser,  // [2:0] status
  output logic                   out_tlast
);

  import deq_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = $clog2(2 * DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_LIST
  } state_t;

  state_t          state_r, state_nxt;
  logic [PW-1:0]   front_r, front_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            out_valid_r;
  logic [31:0]     out_data_r;
  status_t         out_status_r;
  logic            out_last_r;

  logic            ld;
  status_t         ld_status;
  logic [31:0]     ld_data;
  logic            ld_last;

  logic                  ram_we, ram_re;
  logic [PW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  cmd_t          in_cmd;
  logic [31:0]   in_value;
  logic [63:0]   val_ext, rd_ext;
  logic          slot_free, in_fire, full, empty, list_last;
  logic [PW-1:0] front_inc, front_dec, back_wr, back_rd, list_addr;

  // Fold a sum below twice the depth back into the ring
  function automatic logic [PW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
    return r[PW-1:0];
  endfunction

  // Unpack the input beat and size values
  assign in_cmd    = cmd_t'(in_tdata[2:0]);
  assign in_value  = in_tdata[34:3];
  assign val_ext   = 64'($signed(in_value));
  assign ram_wdata = val_ext[DATA_WIDTH-1:0];
  assign rd_ext    = 64'($signed(ram_rdata));

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign in_fire   = in_tvalid && in_tready;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  // Ring addresses
  assign front_inc = (front_r == PW'(DEPTH - 1)) ? '0 : front_r + PW'(1);
  assign front_dec = (front_r == '0) ? PW'(DEPTH - 1) : front_r - PW'(1);
  assign back_wr   = wrap(SW'(front_r) + SW'(count_r));
  assign back_rd   = wrap(SW'(front_r) + SW'(count_r) - SW'(1));
  assign list_addr = wrap(SW'(front_r) + SW'(idx_r) + SW'(1));
  assign list_last = ((idx_r + CW'(1)) == count_r);

  // Command decode and sequencing
  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = '0;
    ram_raddr = '0;
    ld        = 1'b0;
    ld_status = ST_PUSHED;
    ld_data   = '0;
    ld_last   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            CMD_PUSH_FRONT: begin
              ld = 1'b1;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_PUSH_BACK: begin
              ld = 1'b1;
              if (full) begin
                ld_status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = back_wr;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_LIST: begin
              if (empty) begin
                ld        = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = front_r;
                idx_nxt   = '0;
                state_nxt = S_LIST;
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                ld        = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = front_r;
                front_nxt = front_inc;
                count_nxt = count_r - CW'(1);
                state_nxt = S_POP;
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                ld        = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = back_rd;
                count_nxt = count_r - CW'(1);
                state_nxt = S_POP;
              end
            end
            CMD_CLEAR: begin
              ld        = 1'b1;
              ld_status = ST_CLEARED;
              front_nxt = '0;
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        // Read data holds in the RAM register until the slot frees
        if (slot_free) begin
          ld        = 1'b1;
          ld_status = ST_POPPED;
          ld_data   = rd_ext[31:0];
          state_nxt = S_IDLE;
        end
      end
      S_LIST: begin
        // Emit one entry and fetch the next
        if (slot_free) begin
          ld        = 1'b1;
          ld_status = ST_LISTED;
          ld_data   = rd_ext[31:0];
          ld_last   = list_last;
          if (list_last) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = list_addr;
            idx_nxt   = idx_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (ld) begin
      out_status_r <= ld_status;
      out_data_r   <= ld_data;
      out_last_r   <= ld_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Fill count stays within the ring
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(DEPTH))
    else $error("fill count exceeds depth");

  // Front pointer stays within the ring
  assert property (@(posedge clk) disable iff (!rst_n) front_r <= PW'(DEPTH - 1))
    else $error("front pointer out of range");

  // Writes and reads never share a cycle, so no forwarding is needed
  assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
    else $error("RAM read and write in the same cycle");

  // A successful push grows the queue by one
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_cmd == CMD_PUSH_FRONT || in_cmd == CMD_PUSH_BACK) && !full)
    |=> (count_r == $past(count_r) + CW'(1)))
    else $error("push did not grow the queue");

  // Only listed entries may be followed by more beats
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_status_r == ST_LISTED))
    else $error("non-final beat that is not a listed entry");

endmodule
`default_nettype wire

// ===== test/double_ended_queue_ring_core_tb.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_ring_core_tb - self-checking bench for the deque core
// Drives command beats on the in_ stream, models the deque alongside the
// block, and compares every result beat on the out_ stream in order.
// ----------------------------------------------------------------------------
module double_ended_queue_ring_core_tb;
  import deq_pkg::*;

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned DATA_WIDTH    = 32;
  localparam int unsigned CLK_PERIOD    = 8;
  localparam int unsigned RESET_CYCLES  = 11;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned LIMIT_CYCLES  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS  = 55;

  // Codes outside the command set; the block drops them
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // One result beat as the block should present it
  typedef struct packed {
    status_t     status;
    logic [31:0] data;
    logic        last;
  } result_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [39:0]      in_tdata;   // [2:0] command, [34:3] value, [39:35] zero
  logic             out_tvalid;
  logic             out_tready;
  logic [31:0]      out_tdata;  // [31:0] data
  status_t          out_tuser;  // [2:0] status
  logic             out_tlast;

  // Shadow deque state
  logic [31:0]      ring_mem [DEPTH];
  int unsigned      head_pos;
  int unsigned      fill_cnt;
  result_t          pending_results [$];

  // Traffic shaping
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;
  logic             recv_hold;
  event             hold_go;

  // Run statistics
  int unsigned      fail_cnt;
  int unsigned      items_sent;
  int unsigned      beats_checked;
  int unsigned      lists_sent;
  int unsigned      full_rejects;
  int unsigned      empty_hits;

  double_ended_queue_ring_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Free-running clock
  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Queue one expected result beat
  function automatic void queue_result(status_t st, logic [31:0] d, logic lst);
    result_t r;
    r.status = st;
    r.data   = d;
    r.last   = lst;
    pending_results.push_back(r);
  endfunction

  // Apply one accepted command to the shadow deque and record its results
  task automatic apply_to_deque(input logic [2:0] cmd, input logic [31:0] val);
    int unsigned slot;
    int unsigned i;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill_cnt == DEPTH) begin
          queue_result(ST_FULL, '0, 1'b1);
          full_rejects++;
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            head_pos = (head_pos + DEPTH - 1) % DEPTH;
            slot = head_pos;
          end else begin
            slot = (head_pos + fill_cnt) % DEPTH;
          end
          ring_mem[slot] = val;
          fill_cnt++;
          queue_result(ST_PUSHED, '0, 1'b1);
        end
      end
      CMD_LIST: begin
        lists_sent++;
        if (fill_cnt == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
          empty_hits++;
        end else begin
          for (i = 0; i < fill_cnt; i++) begin
            queue_result(ST_LISTED, ring_mem[(head_pos + i) % DEPTH], i + 1 == fill_cnt);
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (fill_cnt == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
          empty_hits++;
        end else begin
          if (cmd == CMD_POP_FRONT) begin
            slot = head_pos;
            head_pos = (head_pos + 1) % DEPTH;
          end else begin
            slot = (head_pos + fill_cnt - 1) % DEPTH;
          end
          fill_cnt--;
          queue_result(ST_POPPED, ring_mem[slot], 1'b1);
        end
      end
      CMD_CLEAR: begin
        head_pos = 0;
        fill_cnt = 0;
        queue_result(ST_CLEARED, '0, 1'b1);
      end
      default: begin
        // drop spare codes: no state change, no result
      end
    endcase
  endtask

  // Offer one command beat, wait for the handshake, then predict
  task automatic send_command(input logic [2:0] cmd, input logic [31:0] val);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, val, cmd};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    items_sent++;
    apply_to_deque(cmd, val);
  endtask

  // Receiver: random stalls plus the long hold-off window
  always @(posedge clk) begin
    out_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Hold the receiver off for a fixed stretch on request
  initial begin
    recv_hold = 1'b0;
    forever begin
      @(hold_go);
      recv_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      recv_hold <= 1'b0;
    end
  end

  // Compare each result beat ahead of the edge that takes it
  always @(negedge clk) begin
    result_t exp_beat;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d data %0d last %0b",
               out_tuser, $signed(out_tdata), out_tlast);
        fail_cnt++;
      end else begin
        exp_beat = pending_results.pop_front();
        beats_checked++;
        if (out_tuser !== exp_beat.status) begin
          $error("status mismatch: expected %0d actual %0d", exp_beat.status, out_tuser);
          fail_cnt++;
        end
        if (out_tdata !== exp_beat.data) begin
          $error("data mismatch: expected %0d actual %0d",
                 $signed(exp_beat.data), $signed(out_tdata));
          fail_cnt++;
        end
        if (out_tlast !== exp_beat.last) begin
          $error("last mismatch: expected %0b actual %0b", exp_beat.last, out_tlast);
          fail_cnt++;
        end
      end
    end
  end

  // Pick a value, leaning on the extremes now and then
  function automatic logic [31:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Empty-queue cases, extreme values, every command and the spare codes
  task automatic test_directed_edges();
    send_command(CMD_POP_FRONT, 32'h1234_5678);
    send_command(CMD_POP_BACK, 32'h0);
    send_command(CMD_LIST, 32'hFFFF_FFFF);
    send_command(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    send_command(CMD_PUSH_BACK, 32'h8000_0000);
    send_command(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    send_command(CMD_PUSH_BACK, 32'h0000_0000);
    send_command(CMD_LIST, 32'h0);
    send_command(CMD_POP_FRONT, 32'h0);
    send_command(CMD_POP_BACK, 32'h0);
    send_command(CMD_SPARE_6, 32'hDEAD_BEEF);
    send_command(CMD_SPARE_7, 32'h5555_AAAA);
    send_command(CMD_LIST, 32'h0);
    send_command(CMD_POP_BACK, 32'h0);
    send_command(CMD_POP_FRONT, 32'h0);
    send_command(CMD_POP_FRONT, 32'h0);
    send_command(CMD_PUSH_BACK, 32'hAAAA_5555);
    send_command(CMD_CLEAR, 32'hFFFF_FFFF);
    send_command(CMD_LIST, 32'h0);
    send_command(CMD_POP_BACK, 32'h0);
  endtask

  // Fill past capacity, then stall the receiver across a list of the full
  // queue while commands keep coming, then drain
  task automatic test_backpressure_fill();
    int unsigned i;
    send_command(CMD_CLEAR, 32'h0);
    for (i = 0; i < DEPTH + 4; i++) begin
      send_command($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
    end
    -> hold_go;
    send_command(CMD_LIST, 32'h0);
    for (i = 0; i < 4; i++) begin
      send_command($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK, 32'h0);
    end
    send_command(CMD_LIST, 32'h0);
  endtask

  // Random command mix; windows alternate between filling and draining
  task automatic test_random_mix(input int unsigned n_items);
    int unsigned counted;
    int unsigned r;
    int unsigned push_share;
    counted = 0;
    while (counted < n_items) begin
      r = $urandom_range(99);
      push_share = ((counted / 24) % 2 == 0) ? 60 : 25;
      if (r < 3) begin
        send_command($urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7, $urandom);
      end else begin
        counted++;
        if (r < 3 + push_share) begin
          send_command($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
        end else if (r < 13 + push_share) begin
          send_command(CMD_LIST, $urandom);
        end else if (r < 15 + push_share) begin
          send_command(CMD_CLEAR, $urandom);
        end else begin
          send_command($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK, $urandom);
        end
      end
    end
  endtask

  // Main sequence
  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    head_pos       = 0;
    fill_cnt       = 0;
    fail_cnt       = 0;
    items_sent     = 0;
    beats_checked  = 0;
    lists_sent     = 0;
    full_rejects   = 0;
    empty_hits     = 0;
    send_idle_pct  = 7;
    recv_stall_pct = 86;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_random_mix(RANDOM_ITEMS);

    send_idle_pct  = 86;
    recv_stall_pct = 7;
    test_random_mix(RANDOM_ITEMS);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_backpressure_fill();
    test_random_mix(RANDOM_ITEMS);

    // Drain outstanding results, then watch for stray beats
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands and %0d result beats: %0d lists, %0d full rejects,",
             items_sent, beats_checked, lists_sent, full_rejects);
    $display("%0d empty hits, spare codes, and a long receiver stall with the queue full",
             empty_hits);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("status: fail");
    $finish;
  end

endmodule
